@@ sv/frls_pkg.sv @@
// Shared types, constants and record helpers for the record log store.
// Used by frls_page and flash_record_log_store; depends on nothing.
`timescale 1ns / 1ps

package frls_pkg;

    localparam int RECORD_SLOTS = 64;
    localparam int SLOT_W       = (RECORD_SLOTS > 2) ? $clog2(RECORD_SLOTS) : 1;
    localparam int CNT_W        = $clog2(RECORD_SLOTS + 1);

    localparam logic [31:0] REC_MAGIC = 32'h4155_4431;
    localparam logic [31:0] REC_SEED  = 32'hC39A_5A6D;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [15:0] HALF_MASK = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_SCAN    = 2'd1,
        CMD_REQUEST = 2'd2,
        CMD_TASK    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_DEFERRED = 3'd1,
        ST_SAVED    = 3'd2,
        ST_ERROR    = 3'd3,
        ST_ACCEPTED = 3'd4,
        ST_REJECTED = 3'd5,
        ST_LOADED   = 3'd6,
        ST_SCANNED  = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SEARCH,
        S_DECIDE,
        S_VERIFY_RD,
        S_VERIFY_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  slot_index;
        logic [31:0] rec_magic;
        logic [31:0] rec_sequence;
        logic [31:0] rec_value_word;
        logic [31:0] rec_check;
        logic [15:0] asked_value;
        logic        allow_erase;
        logic        fault;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] current_value;
        logic [15:0] saved_value;
        logic        pending;
        logic        error_flag;
        logic [5:0]  written_slot;
    } out_item_t;

    typedef struct packed {
        logic [31:0] magic;
        logic [31:0] seq;
        logic [31:0] word;
        logic [31:0] check;
    } record_t;

    typedef struct packed {
        logic              wr_en;
        logic              erase;
        logic [SLOT_W-1:0] wr_addr;
        record_t           wr_data;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
    } page_req_t;

    function automatic logic [31:0] check_of(input logic [31:0] seq, input logic [31:0] word);
        check_of = REC_MAGIC ^ seq ^ word ^ REC_SEED;
    endfunction

    function automatic logic rec_valid(input record_t r);
        rec_valid = (r.magic == REC_MAGIC) && (r.word[15:0] != 16'd0)
                    && ((r.word[15:0] ^ r.word[31:16]) == HALF_MASK)
                    && (r.check == check_of(r.seq, r.word));
    endfunction

    function automatic logic rec_empty(input record_t r);
        rec_empty = (r.magic == ALL_ONES) && (r.seq == ALL_ONES)
                    && (r.word == ALL_ONES) && (r.check == ALL_ONES);
    endfunction

    function automatic logic seq_newer(input logic [31:0] cand, input logic [31:0] cur);
        logic [31:0] d;
        d = cand - cur;
        seq_newer = (d != 32'd0) && !d[31];
    endfunction

    function automatic logic [31:0] seq_inc(input logic [31:0] v);
        logic [31:0] n;
        n = v + 32'd1;
        seq_inc = ((n == 32'd0) || (n == ALL_ONES)) ? 32'd1 : n;
    endfunction

    function automatic logic [31:0] make_word(input logic [15:0] v);
        make_word = {~v, v};
    endfunction

endpackage

@@ sv/frls_page.sv @@
// Record page: one write port, one registered read port, per-slot valid bits.
// Slots never written since reset or erase read as all ones. Depends on frls_pkg.
`timescale 1ns / 1ps

module frls_page (
    input  logic                clk,
    input  logic                rst_n,
    input  frls_pkg::page_req_t req,
    output frls_pkg::record_t   rd_data
);

    frls_pkg::record_t              mem [frls_pkg::RECORD_SLOTS];
    logic [frls_pkg::RECORD_SLOTS-1:0] vld_reg, vld_next;
    frls_pkg::record_t              rd_mem_reg;
    logic                           rd_hit_reg;

    always_comb
    begin
        vld_next = req.erase ? '0 : vld_reg;
        if (req.wr_en)
        begin
            vld_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (req.rd_en)
            begin
                rd_hit_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_mem_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_mem_reg : '1;

endmodule

@@ sv/flash_record_log_store.sv @@
// Record log store for one 16-bit value kept in a page of 128-bit records.
// Load and request items go straight to their result, a scan reads every slot and a
// save task searches for a free slot; a result waiting on out_ready holds the next item
// off. The page memory's single read port, one slot per cycle, sets the scan and
// free-slot search. Depends on frls_pkg, frls_page.
`timescale 1ns / 1ps

module flash_record_log_store (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  frls_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output frls_pkg::out_item_t out_data
);

    localparam int SW = frls_pkg::SLOT_W;
    localparam int CW = frls_pkg::CNT_W;

    frls_pkg::state_t    state_reg, state_next;
    frls_pkg::in_item_t  item_reg, item_next;
    logic [CW-1:0]       iss_reg, iss_next;
    logic                chk_reg, chk_next;
    logic                found_reg, found_next;
    logic [31:0]         best_seq_reg, best_seq_next;
    logic [15:0]         best_val_reg, best_val_next;
    logic                have_reg, have_next;
    logic [SW-1:0]       chk_idx_reg, chk_idx_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [15:0]         req_val_reg, req_val_next;
    logic [15:0]         comm_val_reg, comm_val_next;
    logic [31:0]         next_seq_reg, next_seq_next;
    logic                waiting_reg, waiting_next;
    logic                failed_reg, failed_next;
    frls_pkg::status_t   status_reg, status_next;
    logic [5:0]          wslot_reg, wslot_next;
    logic                out_valid_reg, out_valid_next;
    frls_pkg::out_item_t out_data_reg, out_data_next;

    frls_pkg::page_req_t page_req;
    frls_pkg::record_t   rd_rec;
    logic [31:0]         load_idx;
    logic [31:0]         slot_ext;
    logic                iss_done;
    logic                rec_ok;
    logic                rec_newer;
    logic                rec_free;

    frls_page u_page (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (page_req),
        .rd_data (rd_rec)
    );

    assign load_idx  = 32'(in_data.slot_index);
    assign slot_ext  = 32'(slot_reg);
    assign iss_done  = (iss_reg == CW'(frls_pkg::RECORD_SLOTS));
    assign rec_ok    = frls_pkg::rec_valid(rd_rec);
    assign rec_newer = frls_pkg::seq_newer(rd_rec.seq, best_seq_reg);
    assign rec_free  = frls_pkg::rec_empty(rd_rec);

    assign in_ready  = (state_reg == frls_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= frls_pkg::S_IDLE;
            iss_reg       <= '0;
            chk_reg       <= 1'b0;
            found_reg     <= 1'b0;
            have_reg      <= 1'b0;
            req_val_reg   <= 16'd1;
            comm_val_reg  <= 16'd1;
            next_seq_reg  <= 32'd1;
            waiting_reg   <= 1'b0;
            failed_reg    <= 1'b0;
            status_reg    <= frls_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            chk_reg       <= chk_next;
            found_reg     <= found_next;
            have_reg      <= have_next;
            req_val_reg   <= req_val_next;
            comm_val_reg  <= comm_val_next;
            next_seq_reg  <= next_seq_next;
            waiting_reg   <= waiting_next;
            failed_reg    <= failed_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        best_seq_reg <= best_seq_next;
        best_val_reg <= best_val_next;
        chk_idx_reg  <= chk_idx_next;
        slot_reg     <= slot_next;
        wslot_reg    <= wslot_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        iss_next       = iss_reg;
        chk_next       = 1'b0;
        found_next     = found_reg;
        best_seq_next  = best_seq_reg;
        best_val_next  = best_val_reg;
        have_next      = have_reg;
        chk_idx_next   = chk_idx_reg;
        slot_next      = slot_reg;
        req_val_next   = req_val_reg;
        comm_val_next  = comm_val_reg;
        next_seq_next  = next_seq_reg;
        waiting_next   = waiting_reg;
        failed_next    = failed_reg;
        status_next    = status_reg;
        wslot_next     = wslot_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        page_req         = '0;
        page_req.wr_data = '0;

        unique case (state_reg)
            frls_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    wslot_next = 6'd0;
                    iss_next   = '0;
                    found_next = 1'b0;
                    have_next  = 1'b0;
                    unique case (frls_pkg::cmd_t'(in_data.cmd))
                        frls_pkg::CMD_LOAD:
                        begin
                            if (load_idx < 32'(frls_pkg::RECORD_SLOTS))
                            begin
                                page_req.wr_en   = 1'b1;
                                page_req.wr_addr = load_idx[SW-1:0];
                                page_req.wr_data = {in_data.rec_magic, in_data.rec_sequence,
                                                    in_data.rec_value_word, in_data.rec_check};
                            end
                            status_next = frls_pkg::ST_LOADED;
                            state_next  = frls_pkg::S_DONE;
                        end
                        frls_pkg::CMD_SCAN:
                        begin
                            state_next = frls_pkg::S_SCAN;
                        end
                        frls_pkg::CMD_REQUEST:
                        begin
                            if (in_data.asked_value == 16'd0)
                            begin
                                status_next = frls_pkg::ST_REJECTED;
                            end
                            else
                            begin
                                req_val_next = in_data.asked_value;
                                waiting_next = (in_data.asked_value != comm_val_reg);
                                failed_next  = 1'b0;
                                status_next  = frls_pkg::ST_ACCEPTED;
                            end
                            state_next = frls_pkg::S_DONE;
                        end
                        frls_pkg::CMD_TASK:
                        begin
                            if (waiting_reg)
                            begin
                                state_next = frls_pkg::S_SEARCH;
                            end
                            else
                            begin
                                status_next = frls_pkg::ST_IDLE;
                                state_next  = frls_pkg::S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = frls_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            frls_pkg::S_SCAN, frls_pkg::S_SEARCH:
            begin
                if (!iss_done)
                begin
                    page_req.rd_en   = 1'b1;
                    page_req.rd_addr = iss_reg[SW-1:0];
                    chk_next         = 1'b1;
                    chk_idx_next     = iss_reg[SW-1:0];
                    iss_next         = iss_reg + CW'(1);
                end
                if (state_reg == frls_pkg::S_SCAN)
                begin
                    if (chk_reg && rec_ok && (!found_reg || rec_newer))
                    begin
                        found_next    = 1'b1;
                        best_seq_next = rd_rec.seq;
                        best_val_next = rd_rec.word[15:0];
                    end
                    if (iss_done && !chk_reg)
                    begin
                        req_val_next  = found_reg ? best_val_reg : 16'd1;
                        comm_val_next = found_reg ? best_val_reg : 16'd1;
                        next_seq_next = found_reg ? frls_pkg::seq_inc(best_seq_reg) : 32'd1;
                        waiting_next  = 1'b0;
                        failed_next   = 1'b0;
                        status_next   = frls_pkg::ST_SCANNED;
                        state_next    = frls_pkg::S_DONE;
                    end
                end
                else
                begin
                    if (chk_reg && !have_reg && rec_free)
                    begin
                        have_next = 1'b1;
                        slot_next = chk_idx_reg;
                    end
                    if (have_reg || (iss_done && !chk_reg))
                    begin
                        chk_next   = 1'b0;
                        state_next = frls_pkg::S_DECIDE;
                    end
                end
            end

            frls_pkg::S_DECIDE:
            begin
                if (!have_reg && !item_reg.allow_erase)
                begin
                    status_next = frls_pkg::ST_DEFERRED;
                    state_next  = frls_pkg::S_DONE;
                end
                else if (item_reg.fault)
                begin
                    waiting_next = 1'b0;
                    failed_next  = 1'b1;
                    status_next  = frls_pkg::ST_ERROR;
                    state_next   = frls_pkg::S_DONE;
                end
                else
                begin
                    page_req.erase         = !have_reg;
                    page_req.wr_en         = 1'b1;
                    page_req.wr_addr       = have_reg ? slot_reg : '0;
                    page_req.wr_data.magic = frls_pkg::REC_MAGIC;
                    page_req.wr_data.seq   = next_seq_reg;
                    page_req.wr_data.word  = frls_pkg::make_word(req_val_reg);
                    page_req.wr_data.check = frls_pkg::check_of(next_seq_reg,
                                                 frls_pkg::make_word(req_val_reg));
                    slot_next              = have_reg ? slot_reg : '0;
                    waiting_next           = 1'b0;
                    state_next             = frls_pkg::S_VERIFY_RD;
                end
            end

            frls_pkg::S_VERIFY_RD:
            begin
                page_req.rd_en   = 1'b1;
                page_req.rd_addr = slot_reg;
                state_next       = frls_pkg::S_VERIFY_CHK;
            end

            frls_pkg::S_VERIFY_CHK:
            begin
                if (rec_ok)
                begin
                    comm_val_next = req_val_reg;
                    next_seq_next = frls_pkg::seq_inc(next_seq_reg);
                    status_next   = frls_pkg::ST_SAVED;
                    wslot_next    = slot_ext[5:0];
                end
                else
                begin
                    failed_next = 1'b1;
                    status_next = frls_pkg::ST_ERROR;
                end
                state_next = frls_pkg::S_DONE;
            end

            frls_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = status_reg;
                    out_data_next.current_value = req_val_reg;
                    out_data_next.saved_value   = comm_val_reg;
                    out_data_next.pending       = waiting_reg;
                    out_data_next.error_flag    = failed_reg;
                    out_data_next.written_slot  = wslot_reg;
                    state_next                  = frls_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = frls_pkg::S_IDLE;
            end
        endcase
    end

endmodule
